/* rtl/core/rra_pkg.sv */
// Package for the running RMS accumulator: widths, limits, microcode types.
// Used by rra_seq, rra_datapath and running_rms_accumulator; no dependencies.
package rra_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SQ_W        = 2 * SAMPLE_W;
  localparam int SUM_W       = 47;
  localparam int COUNT_W     = 17;
  localparam int RMS_W       = 16;
  localparam int RAD_W       = SUM_W + 1;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int SREM_W      = ROOT_W + 2;
  localparam int ITER_W      = 6;
  localparam int PC_W        = 3;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES  = COUNT_W'(65536);
  localparam logic [ITER_W-1:0]  DIV_LAST     = ITER_W'(SUM_W - 1);
  localparam logic [ITER_W-1:0]  SQRT_LAST    = ITER_W'(ROOT_W - 1);
  localparam logic [RMS_W-1:0]   RMS_MAX      = '1;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_SQUARE    = 3'd1,
    OP_ACCUM     = 3'd2,
    OP_DIV_INIT  = 3'd3,
    OP_DIV_STEP  = 3'd4,
    OP_SQRT_INIT = 3'd5,
    OP_SQRT_STEP = 3'd6,
    OP_EMIT      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_NO_REQ   = 3'd1,
    COND_FULL     = 3'd2,
    COND_LOOP     = 3'd3,
    COND_OUT_BUSY = 3'd4
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic loop_more;
    logic out_busy;
  } stat_t;

  localparam pc_t PC_WAIT      = PC_W'(0);
  localparam pc_t PC_SQUARE    = PC_W'(1);
  localparam pc_t PC_ACCUM     = PC_W'(2);
  localparam pc_t PC_DIV_INIT  = PC_W'(3);
  localparam pc_t PC_DIV_STEP  = PC_W'(4);
  localparam pc_t PC_SQRT_INIT = PC_W'(5);
  localparam pc_t PC_SQRT_STEP = PC_W'(6);
  localparam pc_t PC_EMIT      = PC_W'(7);

endpackage

/* rtl/core/rra_seq.sv */
// Microcode sequencer: step counter, read-only program and jump logic.
// Depends on rra_pkg for the control word and status types.
module rra_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  rra_pkg::stat_t stat,
  output rra_pkg::ctrl_t ctrl
);

  rra_pkg::pc_t pc_r;
  rra_pkg::pc_t pc_nxt;
  logic         take_jump;

  function automatic rra_pkg::ctrl_t rom(input rra_pkg::pc_t pc);
    rra_pkg::ctrl_t w;
    w = '{op: rra_pkg::OP_LOAD, cond: rra_pkg::COND_NEVER, target: rra_pkg::PC_WAIT};
    unique case (pc)
      rra_pkg::PC_WAIT: begin
        w = '{rra_pkg::OP_LOAD, rra_pkg::COND_NO_REQ, rra_pkg::PC_WAIT};
      end
      rra_pkg::PC_SQUARE: begin
        w = '{rra_pkg::OP_SQUARE, rra_pkg::COND_FULL, rra_pkg::PC_DIV_INIT};
      end
      rra_pkg::PC_ACCUM: begin
        w = '{rra_pkg::OP_ACCUM, rra_pkg::COND_NEVER, rra_pkg::PC_WAIT};
      end
      rra_pkg::PC_DIV_INIT: begin
        w = '{rra_pkg::OP_DIV_INIT, rra_pkg::COND_NEVER, rra_pkg::PC_WAIT};
      end
      rra_pkg::PC_DIV_STEP: begin
        w = '{rra_pkg::OP_DIV_STEP, rra_pkg::COND_LOOP, rra_pkg::PC_DIV_STEP};
      end
      rra_pkg::PC_SQRT_INIT: begin
        w = '{rra_pkg::OP_SQRT_INIT, rra_pkg::COND_NEVER, rra_pkg::PC_WAIT};
      end
      rra_pkg::PC_SQRT_STEP: begin
        w = '{rra_pkg::OP_SQRT_STEP, rra_pkg::COND_LOOP, rra_pkg::PC_SQRT_STEP};
      end
      rra_pkg::PC_EMIT: begin
        w = '{rra_pkg::OP_EMIT, rra_pkg::COND_OUT_BUSY, rra_pkg::PC_EMIT};
      end
    endcase
    return w;
  endfunction

  assign ctrl = rom(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      rra_pkg::COND_NEVER:    take_jump = 1'b0;
      rra_pkg::COND_NO_REQ:   take_jump = !in_valid;
      rra_pkg::COND_FULL:     take_jump = stat.full;
      rra_pkg::COND_LOOP:     take_jump = stat.loop_more;
      rra_pkg::COND_OUT_BUSY: take_jump = stat.out_busy;
      default:                take_jump = 1'b0;
    endcase
  end

  // The last step falls through to the first by wrapping the step counter.
  assign pc_nxt = take_jump ? ctrl.target : pc_r + rra_pkg::PC_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rra_pkg::PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* rtl/core/rra_datapath.sv */
// Datapath: sum of squares, count, bit-serial divider, square root, result register.
// Depends on rra_pkg; driven one control word per cycle by rra_seq.
module rra_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rra_pkg::ctrl_t                    ctrl,
  output rra_pkg::stat_t                    stat,
  input  logic                              in_valid,
  input  logic signed [rra_pkg::SAMPLE_W-1:0] in_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rra_pkg::RMS_W-1:0]         out_rms,
  output logic [rra_pkg::COUNT_W-1:0]       out_sample_count,
  output logic                              out_overflow
);

  logic [rra_pkg::SAMPLE_W-1:0] mag_r, mag_nxt;
  logic [rra_pkg::SQ_W-1:0]     sq_r, sq_nxt;
  logic [rra_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [rra_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                         over_r, over_nxt;
  logic [rra_pkg::ITER_W-1:0]   iter_r, iter_nxt;
  logic [rra_pkg::SUM_W-1:0]    quo_r, quo_nxt;
  logic [rra_pkg::COUNT_W-1:0]  rem_r, rem_nxt;
  logic [rra_pkg::RAD_W-1:0]    rad_r, rad_nxt;
  logic [rra_pkg::ROOT_W-1:0]   root_r, root_nxt;
  logic [rra_pkg::SREM_W-1:0]   srem_r, srem_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [rra_pkg::RMS_W-1:0]    out_rms_r, out_rms_nxt;
  logic [rra_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                         out_over_r, out_over_nxt;

  logic [rra_pkg::COUNT_W:0]    rem_sh;
  logic [rra_pkg::COUNT_W:0]    rem_diff;
  logic [rra_pkg::SREM_W+1:0]   srem_sh;
  logic [rra_pkg::SREM_W+1:0]   trial;
  logic [rra_pkg::SREM_W+1:0]   srem_diff;
  logic                         out_busy;

  assign out_busy = out_valid_r && out_stall;

  assign rem_sh    = {rem_r, quo_r[rra_pkg::SUM_W-1]};
  assign rem_diff  = rem_sh - {1'b0, count_r};
  assign srem_sh   = {srem_r, rad_r[rra_pkg::RAD_W-1 -: 2]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign srem_diff = srem_sh - trial;

  always_comb begin
    mag_nxt       = mag_r;
    sq_nxt        = sq_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    over_nxt      = over_r;
    iter_nxt      = iter_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    out_rms_nxt   = out_rms_r;
    out_count_nxt = out_count_r;
    out_over_nxt  = out_over_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (ctrl.op)
      rra_pkg::OP_LOAD: begin
        if (in_valid) begin
          mag_nxt  = in_sample[rra_pkg::SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
          over_nxt = (count_r == rra_pkg::MAX_SAMPLES);
        end
      end
      rra_pkg::OP_SQUARE: begin
        sq_nxt = mag_r * mag_r;
      end
      rra_pkg::OP_ACCUM: begin
        sum_nxt   = sum_r + rra_pkg::SUM_W'(sq_r);
        count_nxt = count_r + 1'b1;
      end
      rra_pkg::OP_DIV_INIT: begin
        quo_nxt  = sum_r;
        rem_nxt  = '0;
        iter_nxt = rra_pkg::DIV_LAST;
      end
      rra_pkg::OP_DIV_STEP: begin
        if (!rem_diff[rra_pkg::COUNT_W] || rem_sh[rra_pkg::COUNT_W]) begin
          rem_nxt = rem_diff[rra_pkg::COUNT_W-1:0];
          quo_nxt = {quo_r[rra_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[rra_pkg::COUNT_W-1:0];
          quo_nxt = {quo_r[rra_pkg::SUM_W-2:0], 1'b0};
        end
        iter_nxt = iter_r - 1'b1;
      end
      rra_pkg::OP_SQRT_INIT: begin
        rad_nxt  = {1'b0, quo_r};
        root_nxt = '0;
        srem_nxt = '0;
        iter_nxt = rra_pkg::SQRT_LAST;
      end
      rra_pkg::OP_SQRT_STEP: begin
        if (srem_sh >= trial) begin
          srem_nxt = srem_diff[rra_pkg::SREM_W-1:0];
          root_nxt = {root_r[rra_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = srem_sh[rra_pkg::SREM_W-1:0];
          root_nxt = {root_r[rra_pkg::ROOT_W-2:0], 1'b0};
        end
        rad_nxt  = {rad_r[rra_pkg::RAD_W-3:0], 2'b00};
        iter_nxt = iter_r - 1'b1;
      end
      rra_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_rms_nxt   = (root_r[rra_pkg::ROOT_W-1:rra_pkg::RMS_W] != '0) ?
                          rra_pkg::RMS_MAX : root_r[rra_pkg::RMS_W-1:0];
          out_count_nxt = count_r;
          out_over_nxt  = over_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      count_r     <= '0;
      iter_r      <= '0;
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      iter_r      <= iter_nxt;
      over_r      <= over_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    sq_r        <= sq_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    rad_r       <= rad_nxt;
    root_r      <= root_nxt;
    srem_r      <= srem_nxt;
    out_rms_r   <= out_rms_nxt;
    out_count_r <= out_count_nxt;
    out_over_r  <= out_over_nxt;
  end

  assign stat.full         = over_r;
  assign stat.loop_more    = (iter_r != '0);
  assign stat.out_busy     = out_busy;
  assign out_valid         = out_valid_r;
  assign out_rms           = out_rms_r;
  assign out_sample_count  = out_count_r;
  assign out_overflow      = out_over_r;

`ifndef SYNTHESIS
  a_div_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == rra_pkg::OP_DIV_STEP) |=> (rem_r < count_r))
    else $error("division remainder not below the sample count");

  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == rra_pkg::OP_SQRT_STEP) |=> (srem_r <= {1'b0, root_r, 1'b0}))
    else $error("square root remainder exceeds twice the partial root");

  a_overflow_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_over_r) |-> (out_count_r == rra_pkg::MAX_SAMPLES))
    else $error("overflow reported below the sample limit");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == rra_pkg::OP_ACCUM) |-> (count_r != rra_pkg::MAX_SAMPLES))
    else $error("sample accumulated beyond the limit");
`endif

endmodule

/* rtl/core/running_rms_accumulator.sv */
// Running RMS accumulator: every request carries a signed 16-bit sample and
// yields the root mean square of all samples so far, floor(sqrt(floor(sum/n))).
// Input channel in_valid/in_stall with in_sample; result channel
// out_valid/out_stall with out_rms, out_sample_count and out_overflow.
// A request is taken only while the sequencer waits at its first step, so the
// block works on one sample at a time. Once 65536 samples have been taken the
// accumulate step is skipped; the next request is taken in the cycle the result
// appears. The run time is set by the 47 steps of the bit-serial divider and
// the 24 steps of the digit-by-digit square root, one microcode step per cycle.
// The result sits in an output register; if the receiver stalls it holds, and
// a further result waits at the last step until the register is free.
// After 65536 samples further samples are ignored, out_overflow is set and the
// previous result is repeated. Synchronous active-low reset clears the sum,
// the count and the sequencer; no result is pending after reset.
// Depends on rra_pkg, rra_seq and rra_datapath.
module running_rms_accumulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rra_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rra_pkg::RMS_W-1:0]           out_rms,
  output logic [rra_pkg::COUNT_W-1:0]         out_sample_count,
  output logic                                out_overflow
);

  rra_pkg::ctrl_t ctrl;
  rra_pkg::stat_t stat;

  rra_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  rra_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rms          (out_rms),
    .out_sample_count (out_sample_count),
    .out_overflow     (out_overflow)
  );

  assign in_stall = (ctrl.op != rra_pkg::OP_LOAD);

endmodule
